@@ rtl/sorted_array_symbol_table_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the ordered key/value table
// ---------------------------------------------------------------------------
`ifndef SORTED_ARRAY_SYMBOL_TABLE_DEFINES_SVH
`define SORTED_ARRAY_SYMBOL_TABLE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SAST_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication
`define SAST_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ rtl/sast_pkg.sv @@
// ---------------------------------------------------------------------------
// sast_pkg
// Shared types and codes of the ordered key/value table.
// ---------------------------------------------------------------------------
package sast_pkg;

    localparam int RANK_W = 6;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_SELECT = 2'd2,
        OP_DELETE = 2'd3
    } sast_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_RANK  = 2'd3
    } sast_status_t;

    // per-cycle command broadcast to every cell; ins and del are already qualified
    typedef struct packed {
        logic ins;   // insert, table not full
        logic del;   // delete, key present
        logic srch;  // search
        logic sel;   // select by rank
    } sast_cmd_t;

endpackage

@@ rtl/sast_cell.sv @@
// ---------------------------------------------------------------------------
// sast_cell
// One slot of the table: holds an entry, compares it with the broadcast key
// and shifts toward a neighbor on insert or delete.
// ---------------------------------------------------------------------------
module sast_cell #(
    parameter int INDEX      = 0,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 7
) (
    input  logic                    clk,
    input  sast_pkg::sast_cmd_t     cmd,
    input  logic [KEY_BITS-1:0]     key,
    input  logic [VALUE_BITS-1:0]   value,
    input  logic [sast_pkg::RANK_W-1:0] rank,
    input  logic [CNT_W-1:0]        count,
    input  logic [KEY_BITS-1:0]     left_key,
    input  logic [VALUE_BITS-1:0]   left_value,
    input  logic                    left_gt,
    input  logic                    left_eq,
    input  logic [KEY_BITS-1:0]     right_key,
    input  logic [VALUE_BITS-1:0]   right_value,
    output logic [KEY_BITS-1:0]     entry_key,
    output logic [VALUE_BITS-1:0]   entry_value,
    output logic                    gt,
    output logic                    eq,
    output logic [KEY_BITS-1:0]     pick_key,
    output logic [VALUE_BITS-1:0]   pick_value
);
    import sast_pkg::*;

    localparam int  RANK_SPAN = 2 ** RANK_W;
    localparam logic RANKABLE = (INDEX < RANK_SPAN);
    localparam logic [RANK_W-1:0] RANK_IDX = RANK_W'(INDEX % RANK_SPAN);

    logic [KEY_BITS-1:0]   key_reg,   key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  occ;
    logic                  pick;

    always_comb
    begin
        occ  = (count > CNT_W'(INDEX));
        eq   = occ && (key_reg == key);
        gt   = occ && (key_reg > key);
        // first match: the entry on the left is not an equal key
        pick = (cmd.srch && eq && !left_eq)
            || (cmd.sel && occ && RANKABLE && (rank == RANK_IDX));

        key_next   = key_reg;
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (left_gt)
            begin
                key_next   = left_key;
                value_next = left_value;
            end
            else if (gt || !occ)
            begin
                key_next   = key;
                value_next = value;
            end
        end
        else if (cmd.del && (eq || gt))
        begin
            key_next   = right_key;
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign entry_key   = key_reg;
    assign entry_value = value_reg;
    assign pick_key    = pick ? key_reg   : '0;
    assign pick_value  = pick ? value_reg : '0;

endmodule

@@ rtl/sorted_array_symbol_table.sv @@
// The result of an accepted transaction is registered on the output register in the cycle after it is accepted.
// Throughput: one transaction per cycle while in_ready is high; all cells compare and shift in the same cycle.
// in_ready drops only while a result is held and out_ready is low.
// Reset clears the entry count and the output valid; cell contents are not reset
// and are only read below the count.
module sorted_array_symbol_table #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sast_pkg::sast_op_t          op,
    input  logic [KEY_BITS-1:0]         key,
    input  logic [VALUE_BITS-1:0]       value,
    input  logic [sast_pkg::RANK_W-1:0] rank,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [KEY_BITS-1:0]         out_key,
    output logic [VALUE_BITS-1:0]       out_value,
    output logic [CNT_W-1:0]            entry_count,
    output sast_pkg::sast_status_t      status
);
    import sast_pkg::*;

    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [KEY_BITS-1:0]   cell_pkey  [CAPACITY];
    logic [VALUE_BITS-1:0] cell_pval  [CAPACITY];
    logic [CAPACITY-1:0]   cell_gt;
    logic [CAPACITY-1:0]   cell_eq;

    logic                  accept;
    logic                  any_eq;
    logic                  hit;
    logic [KEY_BITS-1:0]   hit_key;
    logic [VALUE_BITS-1:0] hit_value;
    sast_cmd_t             cmd;
    sast_status_t          status_next;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  valid_reg;
    logic                  found_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    sast_status_t          status_reg;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign any_eq   = |cell_eq;

    always_comb
    begin
        cmd.ins  = accept && (op == OP_INSERT) && (count_reg < CNT_W'(CAPACITY));
        cmd.del  = accept && (op == OP_DELETE) && any_eq;
        cmd.srch = (op == OP_SEARCH);
        cmd.sel  = (op == OP_SELECT);
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [KEY_BITS-1:0]   l_key, r_key;
            logic [VALUE_BITS-1:0] l_value, r_value;
            logic                  l_gt, l_eq;

            if (g == 0)
            begin : g_first
                assign l_key   = '0;
                assign l_value = '0;
                assign l_gt    = 1'b0;
                assign l_eq    = 1'b0;
            end
            else
            begin : g_mid
                assign l_key   = cell_key[g-1];
                assign l_value = cell_value[g-1];
                assign l_gt    = cell_gt[g-1];
                assign l_eq    = cell_eq[g-1];
            end

            // last cell refills from itself; that slot falls out of use on delete
            if (g == CAPACITY - 1)
            begin : g_last
                assign r_key   = cell_key[g];
                assign r_value = cell_value[g];
            end
            else
            begin : g_inner
                assign r_key   = cell_key[g+1];
                assign r_value = cell_value[g+1];
            end

            sast_cell #(
                .INDEX      (g),
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS),
                .CNT_W      (CNT_W)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .key         (key),
                .value       (value),
                .rank        (rank),
                .count       (count_reg),
                .left_key    (l_key),
                .left_value  (l_value),
                .left_gt     (l_gt),
                .left_eq     (l_eq),
                .right_key   (r_key),
                .right_value (r_value),
                .entry_key   (cell_key[g]),
                .entry_value (cell_value[g]),
                .gt          (cell_gt[g]),
                .eq          (cell_eq[g]),
                .pick_key    (cell_pkey[g]),
                .pick_value  (cell_pval[g])
            );
        end
    endgenerate

    // at most one cell picks, so OR-ing the gated entries selects it
    always_comb
    begin
        hit_key   = '0;
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_key   = hit_key   | cell_pkey[i];
            hit_value = hit_value | cell_pval[i];
        end
        hit = (hit_key != '0) || (hit_value != '0);
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (cmd.ins)
                    count_next = count_reg + CNT_W'(1);
                else
                    status_next = ST_FULL;
            end
            OP_SEARCH:
            begin
                if (!any_eq)
                    status_next = ST_NOT_FOUND;
            end
            OP_SELECT:
            begin
                if ({1'b0, count_reg} <= (CNT_W+1)'(rank))
                    status_next = ST_BAD_RANK;
            end
            OP_DELETE:
            begin
                if (cmd.del)
                    count_next = count_reg - CNT_W'(1);
                else
                    status_next = ST_NOT_FOUND;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            if (accept)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // a picked entry may hold all-zero key and value, so found comes from status
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg  <= ((op == OP_SEARCH) || (op == OP_SELECT)) && (status_next == ST_OK);
            key_reg    <= hit ? hit_key : '0;
            value_reg  <= hit ? hit_value : '0;
            status_reg <= status_next;
        end
    end

    assign out_valid   = valid_reg;
    assign found       = found_reg;
    assign out_key     = key_reg;
    assign out_value   = value_reg;
    assign entry_count = count_reg;
    assign status      = status_reg;

endmodule

@@ rtl/sast_checker.sv @@
// ---------------------------------------------------------------------------
// sast_checker
// Port-level checks of the ordered key/value table, bound to the top level.
// ---------------------------------------------------------------------------
`include "sorted_array_symbol_table_defines.svh"

module sast_checker #(
    parameter int CAPACITY   = 64,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        found,
    input logic [KEY_BITS-1:0]         out_key,
    input logic [VALUE_BITS-1:0]       out_value,
    input logic [CNT_W-1:0]            entry_count,
    input sast_pkg::sast_status_t      status
);
    import sast_pkg::*;

    `SAST_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "no result after transaction")
    `SAST_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(entry_count) && $stable(status), "stalled result changed")
    `SAST_ASSERT_NOW(a_count_bound, out_valid, entry_count <= CNT_W'(CAPACITY), "entry count over capacity")
    `SAST_ASSERT_NOW(a_found_ok, out_valid && found, status == ST_OK, "found with error status")
    `SAST_ASSERT_NOW(a_miss_zero, out_valid && !found, out_key == '0 && out_value == '0, "entry returned without found")

endmodule

bind sorted_array_symbol_table sast_checker #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_sast_checker (.*);
